[design/toda_pkg.sv]
package toda_pkg;

    // Operation codes carried in tuser
    typedef enum logic [3:0] {
        OP_ADD_S   = 4'd0,
        OP_ADD_M   = 4'd1,
        OP_ADD_H   = 4'd2,
        OP_SUB_S   = 4'd3,
        OP_SUB_M   = 4'd4,
        OP_SUB_H   = 4'd5,
        OP_SET_H   = 4'd6,
        OP_SET_M   = 4'd7,
        OP_SET_S   = 4'd8,
        OP_CLEAR   = 4'd9,
        OP_COMPARE = 4'd10
    } t_op;

    localparam int SECS_PER_MIN  = 60;
    localparam int HOURS_PER_DAY = 24;
    localparam int HOUR_MAX      = 23;
    localparam int MINUTE_MAX    = 59;
    localparam int DAY_BITS      = 16;

    // floor(2^32 / d): the quotient estimate is low by at most one
    localparam logic [31:0] RECIP_60 = 32'd71582788;
    localparam logic [31:0] RECIP_24 = 32'd178956970;

    // Digit levels of the span split: seconds, minutes, hours
    localparam logic [1:0] LVL_SEC  = 2'd0;
    localparam logic [1:0] LVL_MIN  = 2'd1;
    localparam logic [1:0] LVL_HOUR = 2'd2;

    // Per-transaction control and digits that travel down the pipeline
    typedef struct packed {
        t_op             op;
        logic            set_ok;
        logic [5:0]      set_val;
        logic [4:0]      cmp_h;
        logic [5:0]      cmp_m;
        logic [5:0]      cmp_s;
        logic [1:0]      start_lvl;
        logic [2:0][5:0] dig;
    } t_info;

endpackage

[design/time_of_day_accumulator.sv]
// Channel   Dir  Fields (tdata/tuser from bit 0 up)
// -------   ---  -----------------------------------------------------------
// s (in)    in   tuser: op | tdata: amount, cmp_hour, cmp_minute, cmp_second
// m (out)   out  tdata: hour_now, minute_now, second_now, day_carry,
//                       is_before, is_equal, is_after
//
// One transaction per cycle sustained while i_m_tready does not stall the output.
// Six stages after the input register split the span into whole days and
// h:m:s digits (a reciprocal multiply and a correction for each of the radices
// 60, 60 and 24); the last stage applies the digits to the stored time in a
// combinational step, which is the loop that fixes the rate.
// Reset (i_rst_n low, synchronous) clears the time to 00:00:00 and empties
// the pipeline.
// Each stage advances into a free slot on its own, so the input keeps taking
// transactions while a result waits on o_m_tvalid until the pipeline is full.
module time_of_day_accumulator
    import toda_pkg::*;
#(
    parameter int AMOUNT_BITS = 20
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_s_tvalid,
    output logic                                        o_s_tready,
    // amount, cmp_hour[4:0], cmp_minute[5:0], cmp_second[5:0], zero pad
    input  logic [((AMOUNT_BITS + 17 + 7) / 8) * 8 - 1:0] i_s_tdata,
    // op[3:0]
    input  logic [3:0]                                  i_s_tuser,
    output logic                                        o_m_tvalid,
    input  logic                                        i_m_tready,
    // hour_now[4:0], minute_now[5:0], second_now[5:0], day_carry[15:0],
    // is_before, is_equal, is_after, zero pad
    output logic [39:0]                                 o_m_tdata
);

    localparam int NSTG = 8;
    localparam int OUT_STG = NSTG - 1;

    // Stage valids and handshake chain
    logic       r_v    [0:NSTG-1];
    logic       w_rdy  [0:NSTG-1];
    logic       w_vin  [0:NSTG-1];
    logic       w_ld   [0:NSTG-1];

    // Stage payloads
    t_info                  r_inf [0:NSTG-2];
    logic [AMOUNT_BITS-1:0] r_x   [0:3];   // value entering each level
    logic [AMOUNT_BITS-1:0] r_q   [0:2];   // quotient estimate per level
    logic [AMOUNT_BITS-1:0] r_xh  [0:2];   // value held beside the estimate

    // Stored time of day
    logic [4:0] r_hours;
    logic [5:0] r_minutes;
    logic [5:0] r_seconds;
    logic [4:0] n_hours;
    logic [5:0] n_minutes;
    logic [5:0] n_seconds;

    // Result register
    logic [4:0]          r_hr_out;
    logic [5:0]          r_min_out;
    logic [5:0]          r_sec_out;
    logic [DAY_BITS-1:0] r_day_out;
    logic                r_before;
    logic                r_equal;
    logic                r_after;
    logic [DAY_BITS-1:0] n_day;
    logic                n_before;
    logic                n_equal;
    logic                n_after;

    // Input decode
    t_op                    w_op;
    logic [AMOUNT_BITS-1:0] w_amount;
    t_info                  w_inf_in;

    assign w_op     = t_op'(i_s_tuser);
    assign w_amount = i_s_tdata[AMOUNT_BITS-1:0];

    always_comb begin
        w_inf_in         = '0;
        w_inf_in.op      = w_op;
        w_inf_in.set_val = 6'(w_amount);
        w_inf_in.cmp_h   = i_s_tdata[AMOUNT_BITS +: 5];
        w_inf_in.cmp_m   = i_s_tdata[AMOUNT_BITS + 5 +: 6];
        w_inf_in.cmp_s   = i_s_tdata[AMOUNT_BITS + 11 +: 6];
        // Pick the level the span enters at; its lower digits are zero
        case (w_op) inside
            OP_ADD_S, OP_SUB_S: w_inf_in.start_lvl = LVL_SEC;
            OP_ADD_M, OP_SUB_M: w_inf_in.start_lvl = LVL_MIN;
            default:            w_inf_in.start_lvl = LVL_HOUR;
        endcase
        case (w_op) inside
            OP_SET_H:         w_inf_in.set_ok = (w_amount <= AMOUNT_BITS'(HOUR_MAX));
            OP_SET_M, OP_SET_S:
                              w_inf_in.set_ok = (w_amount <= AMOUNT_BITS'(MINUTE_MAX));
            default:          w_inf_in.set_ok = 1'b0;
        endcase
    end

    // Handshake chain: a stage loads when it is empty or its content moves on
    always_comb begin
        w_rdy[OUT_STG] = !r_v[OUT_STG] || i_m_tready;
        for (int k = OUT_STG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k + 1];
        end
        w_vin[0] = i_s_tvalid;
        for (int k = 1; k < NSTG; k++) begin
            w_vin[k] = r_v[k - 1];
        end
        for (int k = 0; k < NSTG; k++) begin
            w_ld[k] = w_rdy[k] && w_vin[k];
        end
    end

    assign o_s_tready = w_rdy[0];
    assign o_m_tvalid = r_v[OUT_STG];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= w_vin[k];
            end
        end
    end

    // Capture the transaction
    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_inf[0] <= w_inf_in;
            r_x[0]   <= w_amount;
        end
    end

    // Three levels of divide by a constant: 60, 60, 24.
    // Odd stage: multiply by the reciprocal. Even stage: form the remainder,
    // correct the estimate once, and drop the remainder into its digit.
    for (genvar l = 0; l < 3; l++) begin : g_lvl
        localparam logic [6:0]  DIV   = (l == 2) ? 7'(HOURS_PER_DAY) : 7'(SECS_PER_MIN);
        localparam logic [31:0] RECIP = (l == 2) ? RECIP_24 : RECIP_60;

        logic [AMOUNT_BITS+31:0] w_prod;
        logic [6:0]              w_rem;
        logic                    w_fix;
        logic                    w_act;
        t_info                   w_inf_nxt;

        assign w_prod = {32'b0, r_x[l]} * {{AMOUNT_BITS{1'b0}}, RECIP};

        always_ff @(posedge i_clk) begin
            if (w_ld[2 * l + 1]) begin
                r_q[l]           <= w_prod[AMOUNT_BITS+31:32];
                r_xh[l]          <= r_x[l];
                r_inf[2 * l + 1] <= r_inf[2 * l];
            end
        end

        // Estimate is low by at most one, so the remainder stays below 2*DIV
        assign w_rem = 7'(r_xh[l] - r_q[l] * AMOUNT_BITS'(DIV));
        assign w_fix = (w_rem >= DIV);
        assign w_act = (2'(l) >= r_inf[2 * l + 1].start_lvl);

        always_comb begin
            w_inf_nxt = r_inf[2 * l + 1];
            if (!w_act) begin
                w_inf_nxt.dig[l] = '0;
            end else if (w_fix) begin
                w_inf_nxt.dig[l] = 6'(w_rem - DIV);
            end else begin
                w_inf_nxt.dig[l] = 6'(w_rem);
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ld[2 * l + 2]) begin
                if (!w_act) begin
                    r_x[l + 1] <= r_xh[l];
                end else begin
                    r_x[l + 1] <= r_q[l] + AMOUNT_BITS'(w_fix);
                end
                r_inf[2 * l + 2] <= w_inf_nxt;
            end
        end
    end

    // Final stage: apply the digits to the stored time
    t_info               w_fin;
    logic [DAY_BITS-1:0] w_days;
    logic [5:0]          w_ds;
    logic [5:0]          w_dm;
    logic [4:0]          w_dh;
    logic [6:0]          w_s_sum;
    logic [6:0]          w_m_sum;
    logic [5:0]          w_h_sum;
    logic                w_c_s;
    logic                w_c_m;
    logic                w_c_h;
    logic                w_b_s;
    logic                w_b_m;
    logic                w_b_h;
    logic [6:0]          w_m_need;
    logic [5:0]          w_h_need;

    assign w_fin  = r_inf[OUT_STG - 1];
    assign w_days = DAY_BITS'(r_x[3]);
    assign w_ds   = w_fin.dig[0];
    assign w_dm   = w_fin.dig[1];
    assign w_dh   = 5'(w_fin.dig[2]);

    always_comb begin
        // Add with carry: seconds, then minutes, then hours into days
        w_s_sum  = 7'(r_seconds) + 7'(w_ds);
        w_c_s    = (w_s_sum >= 7'(SECS_PER_MIN));
        w_m_sum  = 7'(r_minutes) + 7'(w_dm) + 7'(w_c_s);
        w_c_m    = (w_m_sum >= 7'(SECS_PER_MIN));
        w_h_sum  = 6'(r_hours) + 6'(w_dh) + 6'(w_c_m);
        w_c_h    = (w_h_sum >= 6'(HOURS_PER_DAY));
        // Subtract with borrow, same order
        w_b_s    = (r_seconds < w_ds);
        w_m_need = 7'(w_dm) + 7'(w_b_s);
        w_b_m    = (7'(r_minutes) < w_m_need);
        w_h_need = 6'(w_dh) + 6'(w_b_m);
        w_b_h    = (6'(r_hours) < w_h_need);

        n_hours   = r_hours;
        n_minutes = r_minutes;
        n_seconds = r_seconds;
        n_day     = '0;
        n_before  = 1'b0;
        n_equal   = 1'b0;
        n_after   = 1'b0;

        case (w_fin.op) inside
            OP_ADD_S, OP_ADD_M, OP_ADD_H: begin
                n_seconds = w_c_s ? 6'(w_s_sum - 7'(SECS_PER_MIN)) : 6'(w_s_sum);
                n_minutes = w_c_m ? 6'(w_m_sum - 7'(SECS_PER_MIN)) : 6'(w_m_sum);
                n_hours   = w_c_h ? 5'(w_h_sum - 6'(HOURS_PER_DAY)) : 5'(w_h_sum);
                n_day     = w_days + DAY_BITS'(w_c_h);
            end
            OP_SUB_S, OP_SUB_M, OP_SUB_H: begin
                n_seconds = 6'(7'(r_seconds) + (w_b_s ? 7'(SECS_PER_MIN) : 7'd0)
                               - 7'(w_ds));
                n_minutes = 6'(7'(r_minutes) + (w_b_m ? 7'(SECS_PER_MIN) : 7'd0)
                               - w_m_need);
                n_hours   = 5'(6'(r_hours) + (w_b_h ? 6'(HOURS_PER_DAY) : 6'd0)
                               - w_h_need);
                n_day     = w_days + DAY_BITS'(w_b_h);
            end
            OP_SET_H: begin
                if (w_fin.set_ok) begin
                    n_hours = 5'(w_fin.set_val);
                end
            end
            OP_SET_M: begin
                if (w_fin.set_ok) begin
                    n_minutes = w_fin.set_val;
                end
            end
            OP_SET_S: begin
                if (w_fin.set_ok) begin
                    n_seconds = w_fin.set_val;
                end
            end
            OP_CLEAR: begin
                n_hours   = '0;
                n_minutes = '0;
                n_seconds = '0;
            end
            OP_COMPARE: begin
                // Hour decides first, then minute, then second
                if (r_hours != w_fin.cmp_h) begin
                    n_before = (r_hours < w_fin.cmp_h);
                end else if (r_minutes != w_fin.cmp_m) begin
                    n_before = (r_minutes < w_fin.cmp_m);
                end else if (r_seconds != w_fin.cmp_s) begin
                    n_before = (r_seconds < w_fin.cmp_s);
                end else begin
                    n_equal = 1'b1;
                end
                n_after = !n_before && !n_equal;
            end
            default: begin
                // unused codes leave the time alone
            end
        endcase
    end

    // Stored time advances exactly when a transaction enters the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hours   <= '0;
            r_minutes <= '0;
            r_seconds <= '0;
        end else if (w_ld[OUT_STG]) begin
            r_hours   <= n_hours;
            r_minutes <= n_minutes;
            r_seconds <= n_seconds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[OUT_STG]) begin
            r_hr_out  <= n_hours;
            r_min_out <= n_minutes;
            r_sec_out <= n_seconds;
            r_day_out <= n_day;
            r_before  <= n_before;
            r_equal   <= n_equal;
            r_after   <= n_after;
        end
    end

    assign o_m_tdata = {4'b0, r_after, r_equal, r_before, r_day_out,
                        r_sec_out, r_min_out, r_hr_out};

    // Stored time never leaves its range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hours <= 5'(HOUR_MAX)) && (r_minutes <= 6'(MINUTE_MAX))
        && (r_seconds <= 6'(MINUTE_MAX)))
        else $error("stored time out of range");

    // A stalled result freezes the stored time
    a_stall_holds_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable({r_hours, r_minutes, r_seconds}))
        else $error("time changed while result stalled");

    // Reciprocal correction leaves every digit in range
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[OUT_STG - 1] |-> (w_ds <= 6'(MINUTE_MAX)) && (w_dm <= 6'(MINUTE_MAX))
        && (w_dh <= 5'(HOUR_MAX)))
        else $error("span digit out of range");

    // At most one compare flag in a result
    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> $onehot0({r_before, r_equal, r_after}))
        else $error("compare flags not exclusive");

endmodule
